// File: rtl/pdr_pkg.sv
// Shared types, codes and default sizes for the programmable DFA runner.
`timescale 1ns / 1ps

package pdr_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_STATES_DEF  = 16;
  localparam int MAX_SYMBOLS_DEF = 8;
  localparam int SYMBOL_BITS_DEF = 16;

  // Fixed field widths
  localparam int OP_W      = 3;
  localparam int SSEL_W    = 4;
  localparam int LSEL_W    = 3;
  localparam int TARGET_W  = 5;
  localparam int STATUS_W  = 3;
  localparam int CUR_W     = 4;
  localparam int NSTATES_W = 5;
  localparam int NSYMS_W   = 4;
  localparam int START_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;

  // Register reset values
  localparam logic [NSTATES_W-1:0] NSTATES_RST = 5'd16;
  localparam logic [NSYMS_W-1:0]   NSYMS_RST   = 4'd8;
  localparam logic [START_W-1:0]   START_RST   = 4'd0;

  // Stored transition target meaning "dead"
  localparam logic [TARGET_W-1:0] TARGET_DEAD = 5'h1F;

  // Item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WR_TRANS = 3'd0,
    OP_WR_SYM   = 3'd1,
    OP_WR_FLAG  = 3'd2,
    OP_START    = 3'd3,
    OP_STEP     = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_DEAD       = 3'd1,
    ST_UNKNOWN    = 3'd2,
    ST_BAD_TARGET = 3'd3,
    ST_BAD_START  = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATES_IN_USE  = 2'd0,
    CFG_SYMBOLS_IN_USE = 2'd1,
    CFG_START_STATE    = 2'd2
  } cfg_idx_t;

endpackage

// File: rtl/pdr_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
`timescale 1ns / 1ps

module pdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/programmable_dfa_runner_unit.sv
// Top level of the programmable DFA runner: load, start and step items in, one result each.
//
//   channel  direction  handshake            payload
//   in_*     input      in_valid / in_stall  op, state_sel, letter_sel, next_state,
//                                            symbol_code, final_flag
//   out_*    output     out_valid/out_stall  status, accepted, dfa_state
//   cfg_*    input      cfg_wr_en            cfg_index, cfg_wr_data
//
// One item per cycle while out_stall is low; an item passes through the input register and
// then the result register, where its result shows.
// The transition table (one RAM bank per alphabet slot) and the accepting flags are
// read every cycle at the state the next item will see, so a step need not wait for a read.
// Reset clears control state only; table, symbol codes and flags are undefined until
// written. A stalled result holds the input register, which then stalls the input.
`timescale 1ns / 1ps

module programmable_dfa_runner_unit #(
  parameter int MAX_STATES  = pdr_pkg::MAX_STATES_DEF,
  parameter int MAX_SYMBOLS = pdr_pkg::MAX_SYMBOLS_DEF,
  parameter int SYMBOL_BITS = pdr_pkg::SYMBOL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pdr_pkg::OP_W-1:0]            in_op,
  input  logic [pdr_pkg::SSEL_W-1:0]          in_state_sel,
  input  logic [pdr_pkg::LSEL_W-1:0]          in_letter_sel,
  input  logic signed [pdr_pkg::TARGET_W-1:0] in_next_state,
  input  logic signed [SYMBOL_BITS-1:0]       in_symbol_code,
  input  logic                                in_final_flag,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pdr_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_accepted,
  output logic [pdr_pkg::CUR_W-1:0]           out_dfa_state,
  // configuration port
  input  logic                                cfg_wr_en,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pdr_pkg::CFG_DAT_W-1:0]       cfg_wr_data
);

  import pdr_pkg::*;

  localparam int SW   = $clog2(MAX_STATES);
  localparam int LW   = $clog2(MAX_SYMBOLS);
  localparam int LSW  = $clog2(MAX_STATES + 1);
  localparam int NW   = (LSW > NSTATES_W) ? LSW : NSTATES_W;
  localparam int LYW  = $clog2(MAX_SYMBOLS + 1);
  localparam int YW   = (LYW > NSYMS_W) ? LYW : NSYMS_W;

  // Configuration registers
  logic [NSTATES_W-1:0] states_in_use_r;
  logic [NSYMS_W-1:0]   symbols_in_use_r;
  logic [START_W-1:0]   start_state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      states_in_use_r  <= NSTATES_RST;
      symbols_in_use_r <= NSYMS_RST;
      start_state_r    <= START_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STATES_IN_USE:  states_in_use_r  <= cfg_wr_data[NSTATES_W-1:0];
        CFG_SYMBOLS_IN_USE: symbols_in_use_r <= cfg_wr_data[NSYMS_W-1:0];
        CFG_START_STATE:    start_state_r    <= cfg_wr_data[START_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturated counts of states and slots in use
  logic [NW-1:0] states_ext;
  logic [NW-1:0] live_states;
  logic [YW-1:0] syms_ext;
  logic [YW-1:0] live_syms;

  assign states_ext = NW'(states_in_use_r);
  assign syms_ext   = YW'(symbols_in_use_r);

  always_comb begin
    if (states_ext == '0) begin
      live_states = NW'(1);
    end else if (states_ext > NW'(MAX_STATES)) begin
      live_states = NW'(MAX_STATES);
    end else begin
      live_states = states_ext;
    end
    if (syms_ext == '0) begin
      live_syms = YW'(1);
    end else if (syms_ext > YW'(MAX_SYMBOLS)) begin
      live_syms = YW'(MAX_SYMBOLS);
    end else begin
      live_syms = syms_ext;
    end
  end

  // Input register
  logic                       s1_valid_r;
  op_t                        s1_op_r;
  logic [SSEL_W-1:0]          s1_state_sel_r;
  logic [LSEL_W-1:0]          s1_letter_sel_r;
  logic [TARGET_W-1:0]        s1_target_r;
  logic [SYMBOL_BITS-1:0]     s1_code_r;
  logic                       s1_flag_r;
  logic                       in_take;
  logic                       fire;

  // Result register
  logic                       out_valid_r;
  logic [STATUS_W-1:0]        out_status_r;
  logic [CUR_W-1:0]           out_state_r;
  logic                       out_live_r;

  assign fire     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r         <= op_t'(in_op);
      s1_state_sel_r  <= in_state_sel;
      s1_letter_sel_r <= in_letter_sel;
      s1_target_r     <= in_next_state;
      s1_code_r       <= in_symbol_code;
      s1_flag_r       <= in_final_flag;
    end
  end

  // Trace state
  logic [SW-1:0] state_r;
  logic [SW-1:0] state_nxt;
  logic          dead_r;
  logic          dead_nxt;
  logic          err_r;
  logic          err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      dead_r  <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dead_r  <= dead_nxt;
      err_r   <= err_nxt;
    end
  end

  // Selector decode with range checks
  logic [SW+SSEL_W-1:0] ssel_ext;
  logic [LW+LSEL_W-1:0] lsel_ext;
  logic [SW-1:0]        ssel_idx;
  logic [LW-1:0]        lsel_idx;
  logic                 ssel_ok;
  logic                 lsel_ok;

  assign ssel_ext = (SW + SSEL_W)'(s1_state_sel_r);
  assign lsel_ext = (LW + LSEL_W)'(s1_letter_sel_r);
  assign ssel_idx = ssel_ext[SW-1:0];
  assign lsel_idx = lsel_ext[LW-1:0];
  assign ssel_ok  = ssel_ext < (SW + SSEL_W)'(MAX_STATES);
  assign lsel_ok  = lsel_ext < (LW + LSEL_W)'(MAX_SYMBOLS);

  // Symbol code store, one register per slot
  logic [SYMBOL_BITS-1:0] sym_codes_r [MAX_SYMBOLS];
  logic                   sym_we;

  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_codes_r[lsel_idx] <= s1_code_r;
    end
  end

  // Parallel compare, lowest matching slot wins
  logic          found;
  logic [LW-1:0] slot;

  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if ((YW'(i) < live_syms) && (sym_codes_r[i] == s1_code_r)) begin
        found = 1'b1;
        slot  = LW'(i);
      end
    end
  end

  // Transition banks, one per slot, read at the state the next item sees
  logic [TARGET_W-1:0] trn_q [MAX_SYMBOLS];
  logic                trn_we;
  logic [TARGET_W-1:0] trn_wdata;
  logic                trn_fwd_hit_r;
  logic [LW-1:0]       trn_fwd_slot_r;
  logic [TARGET_W-1:0] trn_fwd_data_r;

  assign trn_wdata = s1_target_r[TARGET_W-1] ? TARGET_DEAD : s1_target_r;

  for (genvar b = 0; b < MAX_SYMBOLS; b++) begin : g_trn_bank
    pdr_ram #(
      .WIDTH (TARGET_W),
      .DEPTH (MAX_STATES)
    ) u_trn_ram (
      .clk   (clk),
      .we    (trn_we && (lsel_idx == LW'(b))),
      .waddr (ssel_idx),
      .wdata (trn_wdata),
      .raddr (state_nxt),
      .rdata (trn_q[b])
    );
  end

  // Accepting flags, read at the state the next item sees
  logic flag_q;
  logic flag_we;
  logic flag_fwd_hit_r;
  logic flag_fwd_data_r;
  logic flag_eff;

  pdr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_STATES)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (ssel_idx),
    .wdata (s1_flag_r),
    .raddr (state_nxt),
    .rdata (flag_q)
  );

  // Bypass a write that hit the row being read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trn_fwd_hit_r  <= 1'b0;
      flag_fwd_hit_r <= 1'b0;
    end else begin
      trn_fwd_hit_r  <= trn_we && (ssel_idx == state_nxt);
      flag_fwd_hit_r <= flag_we && (ssel_idx == state_nxt);
    end
  end

  always_ff @(posedge clk) begin
    trn_fwd_slot_r  <= lsel_idx;
    trn_fwd_data_r  <= trn_wdata;
    flag_fwd_data_r <= s1_flag_r;
  end

  assign flag_eff = flag_fwd_hit_r ? flag_fwd_data_r : flag_q;

  // Table entry for the matched slot and its checks
  logic [TARGET_W-1:0] entry;
  logic                step_dead;
  logic [SW-1:0]       step_idx;
  logic                tgt_too_big;
  logic                start_bad;

  assign entry = (trn_fwd_hit_r && (trn_fwd_slot_r == slot)) ? trn_fwd_data_r : trn_q[slot];
  assign step_dead   = entry[TARGET_W-1] || (NW'(entry[TARGET_W-2:0]) >= live_states);
  assign step_idx    = SW'(entry[TARGET_W-2:0]);
  assign tgt_too_big = !s1_target_r[TARGET_W-1] &&
                       (NW'(s1_target_r[TARGET_W-2:0]) >= live_states);
  assign start_bad   = NW'(start_state_r) >= live_states;

  // Item execution
  status_t status_nxt;

  always_comb begin
    state_nxt  = state_r;
    dead_nxt   = dead_r;
    err_nxt    = err_r;
    status_nxt = ST_OK;
    trn_we     = 1'b0;
    sym_we     = 1'b0;
    flag_we    = 1'b0;
    if (fire) begin
      unique case (s1_op_r)
        OP_WR_TRANS: begin
          if (tgt_too_big) begin
            status_nxt = ST_BAD_TARGET;
          end else if (ssel_ok && lsel_ok) begin
            trn_we = 1'b1;
          end
        end
        OP_WR_SYM: begin
          sym_we = lsel_ok;
        end
        OP_WR_FLAG: begin
          flag_we = ssel_ok;
        end
        OP_START: begin
          err_nxt = 1'b0;
          if (start_bad) begin
            state_nxt  = '0;
            dead_nxt   = 1'b1;
            status_nxt = ST_BAD_START;
          end else begin
            state_nxt = SW'(start_state_r);
            dead_nxt  = 1'b0;
          end
        end
        OP_STEP: begin
          if (dead_r) begin
            status_nxt = ST_DEAD;
          end else if (err_r) begin
            status_nxt = ST_UNKNOWN;
          end else if (!found) begin
            err_nxt    = 1'b1;
            status_nxt = ST_UNKNOWN;
          end else if (step_dead) begin
            dead_nxt   = 1'b1;
            status_nxt = ST_DEAD;
          end else begin
            state_nxt = step_idx;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register
  logic [SW+CUR_W-1:0] state_nxt_ext;

  assign state_nxt_ext = (SW + CUR_W)'(state_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= status_nxt;
      out_state_r  <= state_nxt_ext[CUR_W-1:0];
      out_live_r   <= !dead_nxt && !err_nxt;
    end
  end

  // The flag read tracks the present state, which holds while a result waits
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_dfa_state = out_state_r;
  assign out_accepted  = out_live_r && flag_eff;

endmodule
